// ===== hdl/quaternion_to_euler_defines.svh =====
// ----------------------------------------------------------------------------
// quaternion_to_euler assertion macros
// shared property wrappers, clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define Q2E_ASSERT_IMPL(lbl, ante, cons)
`define Q2E_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// widths, fixed-point constants and the arctangent table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int QUAT_W     = 16;
  localparam int QUAT_FRAC  = 14;
  localparam int ANGLE_FRAC = 4;
  localparam int ACC_FRAC   = 16;
  localparam int SUM_W      = 2 * QUAT_W + 2;      // 2*(a*b + c*d)
  localparam int CORDIC_W   = SUM_W + 3;           // room for gain and negation
  localparam int Z_W        = 27;                  // degrees, ACC_FRAC fraction bits
  localparam int ROOT_W     = 2 * QUAT_FRAC + 1;
  localparam int RAD_W      = 4 * QUAT_FRAC + 1;
  localparam int TABLE_LEN  = 24;
  localparam int ROLL_W     = 13;
  localparam int PITCH_W    = 12;
  localparam int HEAD_W     = 13;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/q2e_isqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_isqrt
// pipelined floor square root, one root bit per stage, with a side channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module q2e_isqrt #(
  parameter int SIDE_W = 36
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [q2e_pkg::RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [q2e_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);
  import q2e_pkg::*;

  logic [RAD_W-1:0]  rem_s  [0:ROOT_W];
  logic [ROOT_W-1:0] root_s [0:ROOT_W];
  logic [SIDE_W-1:0] side_s [0:ROOT_W];

  assign rem_s[0]  = rad_i;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int K = ROOT_W - 1 - j;
    logic [RAD_W:0]    trial;
    logic [RAD_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [SIDE_W-1:0] side_q;

    // (q + 2^k)^2 - q^2
    assign trial = ((RAD_W + 1)'(root_s[j]) << (K + 1)) + ((RAD_W + 1)'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= side_s[j];
        if ({1'b0, rem_s[j]} >= trial) begin
          rem_q  <= rem_s[j] - trial[RAD_W-1:0];
          root_q <= root_s[j] | (ROOT_W'(1) << K);
        end else begin
          rem_q  <= rem_s[j];
          root_q <= root_s[j];
        end
      end
    end

    assign rem_s[j+1]  = rem_q;
    assign root_s[j+1] = root_q;
    assign side_s[j+1] = side_q;
  end

  assign root_o = root_s[ROOT_W];
  assign side_o = side_s[ROOT_W];

endmodule

// ===== hdl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2 in degrees, rounded and clamped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module q2e_cordic #(
  parameter int STEPS   = 16,
  parameter int LIM_DEG = 180,
  parameter int OUT_W   = 13
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [q2e_pkg::SUM_W-1:0] y_i,
  input  logic signed [q2e_pkg::SUM_W-1:0] x_i,
  output logic signed [OUT_W-1:0]          angle_o
);
  import q2e_pkg::*;

  localparam logic signed [Z_W-1:0] Z180  = Z_W'(180) <<< ACC_FRAC;
  localparam int                    SH    = ACC_FRAC - ANGLE_FRAC;
  localparam logic signed [Z_W-1:0] HALF  = (SH > 0) ? (Z_W'(1) <<< (SH - 1)) : '0;
  localparam logic signed [Z_W-1:0] LIM_Q = Z_W'(LIM_DEG) <<< ANGLE_FRAC;

  logic signed [CORDIC_W-1:0] x_s    [0:STEPS];
  logic signed [CORDIC_W-1:0] y_s    [0:STEPS];
  logic signed [Z_W-1:0]      z_s    [0:STEPS];
  logic                       zero_s [0:STEPS];

  logic signed [CORDIC_W-1:0] xe, ye;
  logic signed [CORDIC_W-1:0] x0_q, y0_q;
  logic signed [Z_W-1:0]      z0_q;
  logic                       zero0_q;

  assign xe = CORDIC_W'(x_i);
  assign ye = CORDIC_W'(y_i);

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero0_q <= (x_i == '0) && (y_i == '0);
      if (x_i[SUM_W-1]) begin
        x0_q <= -xe;
        y0_q <= -ye;
        z0_q <= y_i[SUM_W-1] ? -Z180 : Z180;
      end else begin
        x0_q <= xe;
        y0_q <= ye;
        z0_q <= '0;
      end
    end
  end

  assign x_s[0]    = x0_q;
  assign y_s[0]    = y0_q;
  assign z_s[0]    = z0_q;
  assign zero_s[0] = zero0_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [CORDIC_W-1:0] x_q, y_q;
    logic signed [Z_W-1:0]      z_q;
    logic                       zero_q;

    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q <= zero_s[i];
        if (!y_s[i][CORDIC_W-1]) begin
          x_q <= x_s[i] + ys;
          y_q <= y_s[i] - xs;
          z_q <= z_s[i] + atan_deg(i);
        end else begin
          x_q <= x_s[i] - ys;
          y_q <= y_s[i] + xs;
          z_q <= z_s[i] - atan_deg(i);
        end
      end
    end

    assign x_s[i+1]    = x_q;
    assign y_s[i+1]    = y_q;
    assign z_s[i+1]    = z_q;
    assign zero_s[i+1] = zero_q;
  end

  // round to output scale and clamp
  logic signed [Z_W-1:0] rnd;
  logic signed [Z_W-1:0] clp;
  logic signed [OUT_W-1:0] angle_q;

  assign rnd = (z_s[STEPS] + HALF) >>> SH;

  always_comb begin
    priority if (rnd > LIM_Q) begin
      clp = LIM_Q;
    end else if (rnd < -LIM_Q) begin
      clp = -LIM_Q;
    end else begin
      clp = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_s[STEPS] ? '0 : clp[OUT_W-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

// ===== hdl/quaternion_to_euler.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler
// unit quaternion (q2.14) to z-y-x euler angles in degrees with 4 fraction bits
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit first)                 | tuser/tlast
//  s_axis   | in  | quat_w, quat_x, quat_y, quat_z (16b each)     | none
//  m_axis   | out | angle_about_x 13b, angle_about_y 12b,        | none
//           |     | heading_angle 13b, 2 zero pad bits           |
//
//  one transfer in per cycle unless the output stalls; the pitch path runs
//  through the 29-stage square-root pipe ahead of its cordic stages, and
//  roll and heading are delayed to line up with pitch
//  a stall at the output freezes the whole pipe; the output register holds
//  reset clears only the valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_to_euler_defines.svh"
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // angle_about_x, angle_about_y, heading_angle, pad
);
  import q2e_pkg::*;

  localparam int L      = ROOT_W + CORDIC_STEPS + 7;   // valid chain length
  localparam int DLY    = ROOT_W + 2;                  // roll/heading alignment
  localparam int FLG    = CORDIC_STEPS + 2;            // pitch saturation alignment
  localparam int PROD_W = 2 * QUAT_W;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< (2 * QUAT_FRAC);
  localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (4 * QUAT_FRAC);
  localparam logic signed [PITCH_W-1:0] P90 = PITCH_W'(90) <<< ANGLE_FRAC;

  // pipe advances whenever the output register is free or being drained
  logic en;
  logic s_accept;
  logic [L-1:0] v_q;

  assign en              = !v_q[L-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign s_accept        = s_axis_tvalid_i && en;
  assign m_axis_tvalid_o = v_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], s_accept};
    end
  end

  // stage 1: the nine products
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  logic signed [PROD_W-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q;
  logic signed [PROD_W-1:0] p_zx_q, p_wz_q, p_xy_q, p_zz_q;

  assign qw = signed'(s_axis_tdata_i[15:0]);
  assign qx = signed'(s_axis_tdata_i[31:16]);
  assign qy = signed'(s_axis_tdata_i[47:32]);
  assign qz = signed'(s_axis_tdata_i[63:48]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= qw * qx;
      p_yz_q <= qy * qz;
      p_xx_q <= qx * qx;
      p_yy_q <= qy * qy;
      p_wy_q <= qw * qy;
      p_zx_q <= qz * qx;
      p_wz_q <= qw * qz;
      p_xy_q <= qx * qy;
      p_zz_q <= qz * qz;
    end
  end

  // stage 2: sine and cosine terms, 28 fraction bits
  logic signed [SUM_W-1:0] sr_q, cr_q, sp_q, sh_q, ch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= (SUM_W'(p_wx_q) + SUM_W'(p_yz_q)) <<< 1;
      cr_q <= ONE - ((SUM_W'(p_xx_q) + SUM_W'(p_yy_q)) <<< 1);
      sp_q <= (SUM_W'(p_wy_q) - SUM_W'(p_zx_q)) <<< 1;
      sh_q <= (SUM_W'(p_wz_q) + SUM_W'(p_xy_q)) <<< 1;
      ch_q <= ONE - ((SUM_W'(p_yy_q) + SUM_W'(p_zz_q)) <<< 1);
    end
  end

  // stage 3: saturation flags and sp squared
  logic signed [SUM_W-1:0]       sp_abs;
  logic [2*QUAT_FRAC-1:0]        sp_mag;
  logic [4*QUAT_FRAC-1:0]        sq_q;
  logic signed [SUM_W-1:0]       sp3_q;
  logic                          sat_pos3_q, sat_neg3_q;

  assign sp_abs = sp_q[SUM_W-1] ? -sp_q : sp_q;
  assign sp_mag = sp_abs[2*QUAT_FRAC-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q       <= sp_mag * sp_mag;
      sp3_q      <= sp_q;
      sat_pos3_q <= sp_q >= ONE;
      sat_neg3_q <= sp_q <= -ONE;
    end
  end

  // stage 4: radicand 1 - sp^2
  logic [RAD_W-1:0]        rad_q;
  logic signed [SUM_W-1:0] sp4_q;
  logic                    sat_pos4_q, sat_neg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q      <= ONE_SQ - RAD_W'(sq_q);
      sp4_q      <= sp3_q;
      sat_pos4_q <= sat_pos3_q;
      sat_neg4_q <= sat_neg3_q;
    end
  end

  // square root for the arcsine abscissa, sp and flags ride along
  logic [ROOT_W-1:0]       root;
  logic [SUM_W+1:0]        sq_side;
  logic signed [SUM_W-1:0] sp_al;
  logic signed [SUM_W-1:0] root_x;

  q2e_isqrt #(
    .SIDE_W (SUM_W + 2)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .side_i ({sat_pos4_q, sat_neg4_q, sp4_q}),
    .root_o (root),
    .side_o (sq_side)
  );

  assign sp_al  = signed'(sq_side[SUM_W-1:0]);
  assign root_x = signed'(SUM_W'(root));

  // three cordic units
  logic signed [ROLL_W-1:0]  roll_ang;
  logic signed [PITCH_W-1:0] pitch_ang;
  logic signed [HEAD_W-1:0]  head_ang;

  q2e_cordic #(
    .STEPS   (CORDIC_STEPS),
    .LIM_DEG (180),
    .OUT_W   (ROLL_W)
  ) u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (sr_q),
    .x_i     (cr_q),
    .angle_o (roll_ang)
  );

  q2e_cordic #(
    .STEPS   (CORDIC_STEPS),
    .LIM_DEG (90),
    .OUT_W   (PITCH_W)
  ) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (sp_al),
    .x_i     (root_x),
    .angle_o (pitch_ang)
  );

  q2e_cordic #(
    .STEPS   (CORDIC_STEPS),
    .LIM_DEG (180),
    .OUT_W   (HEAD_W)
  ) u_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (sh_q),
    .x_i     (ch_q),
    .angle_o (head_ang)
  );

  // alignment delays: roll/heading wait for the square root, flags for the cordic
  logic [ROLL_W+HEAD_W-1:0] rh_dl_q  [0:DLY-1];
  logic [1:0]               flg_dl_q [0:FLG-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rh_dl_q[0]  <= {head_ang, roll_ang};
      flg_dl_q[0] <= sq_side[SUM_W+1:SUM_W];
      for (int k = 1; k < DLY; k++) begin
        rh_dl_q[k] <= rh_dl_q[k-1];
      end
      for (int k = 1; k < FLG; k++) begin
        flg_dl_q[k] <= flg_dl_q[k-1];
      end
    end
  end

  logic                      sat_pos, sat_neg;
  logic signed [PITCH_W-1:0] pitch_fin;

  assign sat_pos = flg_dl_q[FLG-1][1];
  assign sat_neg = flg_dl_q[FLG-1][0];

  // arcsine argument at or past one: exactly +-90 degrees
  always_comb begin
    priority if (sat_pos) begin
      pitch_fin = P90;
    end else if (sat_neg) begin
      pitch_fin = -P90;
    end else begin
      pitch_fin = pitch_ang;
    end
  end

  // output register
  logic [39:0] m_tdata_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_tdata_q <= {2'b00, rh_dl_q[DLY-1][ROLL_W+HEAD_W-1:ROLL_W], pitch_fin,
                    rh_dl_q[DLY-1][ROLL_W-1:0]};
    end
  end

  assign m_axis_tdata_o = m_tdata_q;

  // checks
  `Q2E_ASSERT_NEXT(a_accept_enters, s_accept, v_q[0])
  `Q2E_ASSERT_IMPL(a_sat_excl, sat_pos3_q, !sat_neg3_q)
  `Q2E_ASSERT_IMPL(a_pitch_range, m_axis_tvalid_o,
    ($signed(m_axis_tdata_o[24:13]) <= P90) && ($signed(m_axis_tdata_o[24:13]) >= -P90))
  `Q2E_ASSERT_IMPL(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[39:38] == 2'b00)

endmodule

// ===== dv/tb_quaternion_to_euler.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// streams quaternions into the converter and checks every angle transfer
// against a bit-accurate cordic predictor, under random source and sink gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_quaternion_to_euler;

  localparam int ONE_Q       = 1 << 14;        // 1.0 in q2.14
  localparam int N_STEPS     = 16;
  localparam int LATENCY     = N_STEPS + 36;
  localparam int N_RANDOM    = 1080;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [12:0] heading;
    logic [11:0] pitch;
    logic [12:0] roll;
  } angles_t;

  // directed rows: quaternion, and a typed-in answer where it is obvious
  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 known;
    angles_t            ang;
  } quat_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  angles_t   expected_angles[$];
  int        errors = 0;
  int        cycles = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;
  bit        sink_hold = 1'b0;
  bit        stim_done = 1'b0;
  quat_row_t directed[$];

  always #2 clk_i = ~clk_i;

  quaternion_to_euler #(.CORDIC_STEPS(N_STEPS)) dut (.*);

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic longint atan_step(int i);
    longint t[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc;
    longint xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: fold over and start from +-180
    if (x < 0) begin
      acc = (y >= 0) ? (longint'(180) <<< 16) : -(longint'(180) <<< 16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin      // zero ordinate rotates clockwise too
        x = x + ys; y = y - xs; acc += atan_step(i);
      end else begin
        x = x - ys; y = y + xs; acc -= atan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint deg_round(longint a, longint lim_deg);
    longint r, lim;
    r = (a + (1 <<< 11)) >>> 12;
    lim = lim_deg * 16;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_angles(logic [63:0] q);
    longint w, x, y, z, one, sr, cr, sp, sh, ch, ap;
    angles_t a;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    one = longint'(1) <<< 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sh = 2 * (w * z + x * y);
    ch = one - 2 * (y * y + z * z);
    if (sp >= one) ap = longint'(90) <<< 16;
    else if (sp <= -one) ap = -(longint'(90) <<< 16);
    else ap = vector_angle(sp, floor_sqrt(one * one - sp * sp));
    a.roll    = 13'(deg_round(vector_angle(sr, cr), 180));
    a.pitch   = 12'(deg_round(ap, 90));
    a.heading = 13'(deg_round(vector_angle(sh, ch), 180));
    return a;
  endfunction

  function automatic quat_row_t row(int w, int x, int y, int z, bit known = 0,
                                    int r = 0, int p = 0, int h = 0);
    quat_row_t t;
    t.w = 16'(w); t.x = 16'(x); t.y = 16'(y); t.z = 16'(z);
    t.known = known;
    t.ang.roll = 13'(r); t.ang.pitch = 12'(p); t.ang.heading = 13'(h);
    return t;
  endfunction

  task automatic send_quat(logic [63:0] q);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= q;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_angles.push_back(euler_angles(q));
  endtask

  function automatic logic [63:0] random_quat();
    logic [63:0] q;
    int m;
    q = {$urandom, $urandom};
    m = $urandom_range(9);
    if (m < 6) begin
      // every part within +-1.0
      for (int k = 0; k < 4; k++)
        q[16*k +: 16] = 16'($signed($urandom_range(2 * ONE_Q)) - ONE_Q);
    end else if (m < 8) begin
      // zero some parts to hit the axes and the zero vector
      for (int k = 0; k < 4; k++)
        if ($urandom_range(1)) q[16*k +: 16] = '0;
    end
    return q;
  endfunction

  // sink: random back pressure, plus a long hold when asked
  always @(posedge clk_i) begin
    if (rst_ni)
      m_axis_tready_i <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // checker
  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[37:0];
      if (expected_angles.size() == 0) begin
        $display("%0t unexpected transfer %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = expected_angles.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t roll exp %0d got %0d", $time, $signed(want.roll),
                   $signed(got.roll));
          errors++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t pitch exp %0d got %0d", $time, $signed(want.pitch),
                   $signed(got.pitch));
          errors++;
        end
        if (got.heading !== want.heading) begin
          $display("%0t heading exp %0d got %0d", $time, $signed(want.heading),
                   $signed(got.heading));
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold while the source keeps offering
  initial begin
    wait (stim_done == 1'b0 && rst_ni);
    repeat (2000) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    quat_row_t r;
    directed.push_back(row(ONE_Q, 0, 0, 0, 1, 0, 0, 0));        // identity
    directed.push_back(row(0, 0, 0, 0));                         // zero vector
    directed.push_back(row(0, ONE_Q, 0, 0, 1, 2880, 0, 0));      // roll 180
    directed.push_back(row(0, 0, 0, ONE_Q, 1, 0, 0, 2880));      // heading 180
    directed.push_back(row(11585, 0, 11585, 0));                 // pitch just under +90
    directed.push_back(row(11585, 0, -11585, 0));                // pitch just under -90
    directed.push_back(row(ONE_Q, 0, ONE_Q, 0, 1, 2880, 1440, 2880));   // pitch past +90
    directed.push_back(row(ONE_Q, 0, -ONE_Q, 0, 1, 2880, -1440, 2880)); // pitch past -90
    directed.push_back(row(ONE_Q, ONE_Q, ONE_Q, ONE_Q));         // beyond one
    directed.push_back(row(-32768, -32768, -32768, -32768));
    directed.push_back(row(32767, 32767, 32767, 32767));
    directed.push_back(row(32767, -32768, 32767, -32768));
    directed.push_back(row(-32768, 32767, -32768, 32767));
    directed.push_back(row(11585, 11585, 0, 0));                 // roll 90
    directed.push_back(row(11585, -11585, 0, 0));
    directed.push_back(row(11585, 0, 0, 11585));                 // heading 90
    directed.push_back(row(0, ONE_Q, 0, 1));                     // negative abscissa
    directed.push_back(row(0, ONE_Q, 0, -1));
    directed.push_back(row(-ONE_Q, 0, 0, 0));
    directed.push_back(row(0, 0, ONE_Q, 0));
    directed.push_back(row(16383, 1, -1, 0));
    directed.push_back(row(-1, -1, -1, -1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      r = directed[i];
      send_quat({r.z, r.y, r.x, r.w});
      if (r.known && euler_angles({r.z, r.y, r.x, r.w}) !== r.ang) begin
        $display("%0t directed row %0d exp %h predicted %h", $time, i, r.ang,
                 euler_angles({r.z, r.y, r.x, r.w}));
        errors++;
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        src_idle_pct = 64; sink_idle_pct = 7;
      end else if (n == 2 * N_RANDOM / 3) begin
        src_idle_pct = 0; sink_idle_pct = 0;
      end else if (n == 0) begin
        src_idle_pct = 7; sink_idle_pct = 64;
      end
      send_quat(random_quat());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;

    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_isqrt.sv
hdl/q2e_cordic.sv
hdl/quaternion_to_euler.sv
dv/tb_quaternion_to_euler.sv
